@@ rtl/thr_pkg.sv @@
// Package for tilt_hue_to_rgb: shared widths, CORDIC angle table and fixed constants.
// No dependencies.
package thr_pkg;

    localparam int CordicSteps = 18;
    localparam int PreShift    = 14;
    localparam int CordicW     = 34;
    localparam int AngW        = 25;
    localparam logic [AngW-1:0] Q16Deg90 = 25'd5898240;
    localparam logic [14:0] FullScale = 15'd32767;

    function automatic logic [AngW-1:0] atan_q16(input logic [4:0] idx);
        logic [AngW-1:0] v;
        unique case (idx)
            5'd0:  v = 25'd2949120;
            5'd1:  v = 25'd1740967;
            5'd2:  v = 25'd919879;
            5'd3:  v = 25'd466945;
            5'd4:  v = 25'd234379;
            5'd5:  v = 25'd117304;
            5'd6:  v = 25'd58666;
            5'd7:  v = 25'd29335;
            5'd8:  v = 25'd14668;
            5'd9:  v = 25'd7334;
            5'd10: v = 25'd3667;
            5'd11: v = 25'd1833;
            5'd12: v = 25'd917;
            5'd13: v = 25'd458;
            5'd14: v = 25'd229;
            5'd15: v = 25'd115;
            5'd16: v = 25'd57;
            5'd17: v = 25'd29;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/tilt_hue_to_rgb.sv @@
// Tilt vector to RGB colour converter (top level, single module).
// Depends on thr_pkg for CORDIC table and widths.
//
// Usage:
//   s_axis: one beat per X/Y tilt pair, tdata = {accel_y, accel_x}
//   (accel_x in bits 15:0). m_axis: one beat per pair, tdata holds
//   red, green, blue, hue_deg from bit 0 upward, zero filled to 40 bits.
//   APB register 0 (address 0) holds max_level, reset value 140.
// Throughput: one pair per cycle when the output is not stalled. Pipeline
//   from input beat to output beat: two input stages
//   (absolute values, squares), the CORDIC load stage, 18 CORDIC steps with
//   the 16-step restoring square root running beside them, five colour math
//   stages and the output register.
// Pipeline: a single global advance enable. The whole pipe moves when the
//   output register is empty or being drained; a stalled receiver freezes
//   every stage, so beats are neither lost nor repeated. s_axis_tready is
//   high whenever the pipe can advance.
// Reset: aresetn (synchronous, active low) clears all valid bits and
//   restores max_level to 140.
// max_level is sampled at the colour stage, so change it only while idle.
module tilt_hue_to_rgb
    import thr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // accel_x[15:0], accel_y[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // red[7:0], green[15:8], blue[23:16], hue_deg[32:24]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // config register
    logic [7:0] max_level_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {24'd0, max_level_reg} : 32'd0;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_level_reg <= 8'd140;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            max_level_reg <= pwdata[7:0];
        end
    end

    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // stage 0: register inputs, sign bits and absolute values
    logic        v0_reg;
    logic        xn0_reg, yn0_reg;
    logic [15:0] a0_reg, b0_reg;
    logic signed [15:0] sx, sy;
    assign sx = s_axis_tdata[15:0];
    assign sy = s_axis_tdata[31:16];
    always_ff @(posedge aclk) begin
        if (!aresetn) v0_reg <= 1'b0;
        else if (adv) v0_reg <= s_axis_tvalid;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            xn0_reg <= sx[15];
            yn0_reg <= sy[15];
            a0_reg  <= sx[15] ? 16'(-sx) : 16'(sx);
            b0_reg  <= sy[15] ? 16'(-sy) : 16'(sy);
        end
    end

    // stage 1: squares (two 16x16 multipliers)
    logic        v1_reg, xn1_reg, yn1_reg;
    logic [15:0] a1_reg, b1_reg;
    logic [31:0] aa1_reg, bb1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= v0_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            xn1_reg <= xn0_reg; yn1_reg <= yn0_reg;
            a1_reg  <= a0_reg;  b1_reg  <= b0_reg;
            aa1_reg <= a0_reg * a0_reg;
            bb1_reg <= b0_reg * b0_reg;
        end
    end

    // CORDIC + sqrt pipeline, 18 stages; sqrt uses 16 of them (2 bits each)
    logic signed [CordicW-1:0] cx_reg [0:CordicSteps];
    logic signed [CordicW-1:0] cy_reg [0:CordicSteps];
    logic signed [AngW:0]      cz_reg [0:CordicSteps];
    logic [1:0]  spec_reg [0:CordicSteps]; // bit0 b==0, bit1 a==0
    logic        cv_reg   [0:CordicSteps];
    logic        cxn_reg  [0:CordicSteps];
    logic        cyn_reg  [0:CordicSteps];
    logic [32:0] rem_reg  [0:CordicSteps];
    logic [15:0] root_reg [0:CordicSteps];

    always_ff @(posedge aclk) begin
        if (!aresetn) cv_reg[0] <= 1'b0;
        else if (adv) cv_reg[0] <= v1_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            cx_reg[0]   <= CordicW'({a1_reg, {PreShift{1'b0}}});
            cy_reg[0]   <= CordicW'({b1_reg, {PreShift{1'b0}}});
            cz_reg[0]   <= '0;
            spec_reg[0] <= {a1_reg == 16'd0, b1_reg == 16'd0};
            cxn_reg[0]  <= xn1_reg;
            cyn_reg[0]  <= yn1_reg;
            rem_reg[0]  <= {1'b0, aa1_reg} + {1'b0, bb1_reg};
            root_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
        logic signed [CordicW-1:0] xs, ys;
        logic [32:0] rem_nx;
        logic [15:0] root_nx;
        assign xs = cx_reg[i] >>> i;
        assign ys = cy_reg[i] >>> i;
        if (i < 16) begin : g_sq
            // restoring root: bring down bit pair 15-i
            logic [32:0] trial, rsh;
            logic        fits;
            assign trial   = {15'd0, root_reg[i], 2'b00} | 33'd1;
            assign rsh     = rem_reg[i] >> (2 * (15 - i));
            assign fits    = rsh >= trial;
            assign root_nx = {root_reg[i][14:0], fits};
            assign rem_nx  = fits ? rem_reg[i] - (trial << (2 * (15 - i))) : rem_reg[i];
        end else begin : g_nosq
            assign root_nx = root_reg[i];
            assign rem_nx  = rem_reg[i];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) cv_reg[i+1] <= 1'b0;
            else if (adv) cv_reg[i+1] <= cv_reg[i];
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (!cy_reg[i][CordicW-1]) begin
                    cx_reg[i+1] <= cx_reg[i] + ys;
                    cy_reg[i+1] <= cy_reg[i] - xs;
                    cz_reg[i+1] <= cz_reg[i] + (AngW+1)'(atan_q16(5'(i)));
                end else begin
                    cx_reg[i+1] <= cx_reg[i] - ys;
                    cy_reg[i+1] <= cy_reg[i] + xs;
                    cz_reg[i+1] <= cz_reg[i] - (AngW+1)'(atan_q16(5'(i)));
                end
                spec_reg[i+1] <= spec_reg[i];
                cxn_reg[i+1]  <= cxn_reg[i];
                cyn_reg[i+1]  <= cyn_reg[i];
                root_reg[i+1] <= root_nx;
                rem_reg[i+1]  <= rem_nx;
            end
        end
    end

    // post stage A: clamp angle, fold quadrant, clamp length
    localparam int L = CordicSteps;
    logic        va_reg;
    logic [AngW+1:0] anga_reg;
    logic [14:0] lena_reg;
    logic [AngW-1:0] tq;
    always_comb begin
        if (spec_reg[L][0]) tq = '0;
        else if (spec_reg[L][1]) tq = Q16Deg90;
        else if (cz_reg[L][AngW]) tq = '0;
        else if (cz_reg[L][AngW-1:0] > Q16Deg90) tq = Q16Deg90;
        else tq = cz_reg[L][AngW-1:0];
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) va_reg <= 1'b0;
        else if (adv) va_reg <= cv_reg[L];
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            priority if (!cxn_reg[L] && !cyn_reg[L]) anga_reg <= (AngW+2)'(tq);
            else if (cxn_reg[L] && !cyn_reg[L])
                anga_reg <= (AngW+2)'({Q16Deg90, 1'b0}) - (AngW+2)'(tq);
            else if (cxn_reg[L])
                anga_reg <= (AngW+2)'({Q16Deg90, 1'b0}) + (AngW+2)'(tq);
            else anga_reg <= (AngW+2)'({Q16Deg90, 2'b00}) - (AngW+2)'(tq);
            lena_reg <= (root_reg[L] > 16'(FullScale)) ? FullScale : root_reg[L][14:0];
        end
    end

    // post stage B: hue, M*(32767-len), hue mod 120 distance
    logic        vb_reg;
    logic [8:0]  hueb_reg;
    logic [22:0] prodb_reg;
    logic [7:0]  mb_reg;
    logic [8:0]  hue_c;
    logic [8:0]  hmod;
    logic [5:0]  dmb_reg;
    logic [6:0]  dm_c;
    assign hue_c = (anga_reg[AngW+1:16] >= 11'd360) ? 9'd0 : anga_reg[24:16];
    always_comb begin
        if (hue_c >= 9'd240) hmod = hue_c - 9'd240;
        else if (hue_c >= 9'd120) hmod = hue_c - 9'd120;
        else hmod = hue_c;
        dm_c = (hmod >= 9'd60) ? 7'(hmod - 9'd60) : 7'(9'd60 - hmod);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) vb_reg <= 1'b0;
        else if (adv) vb_reg <= va_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            hueb_reg  <= hue_c;
            mb_reg    <= max_level_reg;
            prodb_reg <= max_level_reg * (FullScale - lena_reg);
            dmb_reg   <= dm_c[5:0];
        end
    end

    // post stage C: m = prod / 32767 (prod < 2^23: q = (p + (p>>15) + 1) >> 15)
    logic        vc_reg;
    logic [8:0]  huec_reg;
    logic [7:0]  mc_reg, lowc_reg;
    logic [5:0]  dmc_reg;
    logic [23:0] qsum;
    assign qsum = 24'(prodb_reg) + 24'(prodb_reg >> 15) + 24'd1;
    always_ff @(posedge aclk) begin
        if (!aresetn) vc_reg <= 1'b0;
        else if (adv) vc_reg <= vb_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            huec_reg <= hueb_reg;
            mc_reg   <= mb_reg;
            lowc_reg <= qsum[22:15];
            dmc_reg  <= dmb_reg;
        end
    end

    // post stage D: C*(60-dm)
    logic        vd_reg;
    logic [8:0]  hued_reg;
    logic [7:0]  md_reg, lowd_reg;
    logic [13:0] pd_reg;
    logic [7:0]  chroma;
    assign chroma = mc_reg - lowc_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vd_reg <= 1'b0;
        else if (adv) vd_reg <= vc_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            hued_reg <= huec_reg;
            md_reg   <= mc_reg;
            lowd_reg <= lowc_reg;
            pd_reg   <= chroma * (6'd60 - dmc_reg);
        end
    end

    // post stage E: /60 by reciprocal (p <= 15300: (p*17477) >> 20 exact), mid
    logic        ve_reg;
    logic [8:0]  huee_reg;
    logic [7:0]  me_reg, lowe_reg, mide_reg;
    logic [28:0] recip;
    assign recip = pd_reg * 15'd17477;
    always_ff @(posedge aclk) begin
        if (!aresetn) ve_reg <= 1'b0;
        else if (adv) ve_reg <= vd_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            huee_reg <= hued_reg;
            me_reg   <= md_reg;
            lowe_reg <= lowd_reg;
            mide_reg <= recip[27:20] + lowd_reg;
        end
    end

    // output register: sector mapping
    logic [7:0] r_c, g_c, b_c;
    always_comb begin
        priority if (huee_reg < 9'd60)  begin r_c = me_reg;   g_c = mide_reg; b_c = lowe_reg; end
        else if (huee_reg < 9'd120) begin r_c = mide_reg; g_c = me_reg;   b_c = lowe_reg; end
        else if (huee_reg < 9'd180) begin r_c = lowe_reg; g_c = me_reg;   b_c = mide_reg; end
        else if (huee_reg < 9'd240) begin r_c = lowe_reg; g_c = mide_reg; b_c = me_reg;   end
        else if (huee_reg < 9'd300) begin r_c = mide_reg; g_c = lowe_reg; b_c = me_reg;   end
        else begin r_c = me_reg; g_c = lowe_reg; b_c = mide_reg; end
    end
    logic        vo_reg;
    logic [39:0] data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vo_reg <= 1'b0;
        else if (adv) vo_reg <= ve_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) data_reg <= {7'd0, huee_reg, b_c, g_c, r_c};
    end
    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = data_reg;

endmodule
